/* sv/ics_pkg.sv */
// Shared types, codes and helpers for the internet checksum engine.
package ics_pkg;

	localparam int MAX_SEGMENT_BYTES_DEF = 65535;
	localparam int SUM_W = 16;
	localparam int PSUM_W = 19;	// six 16-bit words summed without carry loss
	localparam int QUEUE_DEPTH = 2;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [1:0] REG_INCLUDE_PSEUDO = 2'd0;
	localparam logic [1:0] REG_ZERO_ENABLE    = 2'd1;
	localparam logic [1:0] REG_ZERO_OFFSET    = 2'd2;

	localparam logic [7:0] ZERO_OFFSET_RST = 8'd6;

	typedef enum logic {
		OP_ADD,
		OP_LOAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic                last;
		logic [PSUM_W-1:0]   val;
	} ics_op_t;

	typedef struct packed {
		logic       include_pseudo;
		logic       zero_enable;
		logic [7:0] zero_offset;
	} ics_cfg_t;

	// end-around carry fold of a 19-bit partial sum down to 16 bits
	function automatic logic [SUM_W-1:0] oc_fold(input logic [PSUM_W-1:0] v);
		logic [SUM_W:0] t;
		t = (SUM_W+1)'(v[SUM_W-1:0]) + (SUM_W+1)'(v[PSUM_W-1:SUM_W]);
		return t[SUM_W-1:0] + SUM_W'(t[SUM_W]);
	endfunction

endpackage

/* sv/ics_front.sv */
// Front end: classifies items, pairs bytes into words, zeroes the checksum field.
module ics_front #(
	parameter int MAX_SEGMENT_BYTES = ics_pkg::MAX_SEGMENT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ics_pkg::ics_cfg_t cfg,
	input  logic              kind,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [7:0]        protocol,
	input  logic [15:0]       segment_len,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output ics_pkg::ics_op_t  op
);
	import ics_pkg::*;

	localparam int POS_W = $clog2(MAX_SEGMENT_BYTES + 1);
	localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SEGMENT_BYTES);

	logic [POS_W-1:0] pos_q;
	logic             odd_q;
	logic [7:0]       held_q;

	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  off_ext;
	logic [CMP_W-1:0]  off1_ext;
	logic              zero_hit;
	logic [7:0]        byte_eff;
	logic [PSUM_W-1:0] psum;

	assign pos_ext  = CMP_W'(pos_q);
	assign off_ext  = CMP_W'(cfg.zero_offset);
	assign off1_ext = off_ext + CMP_W'(1);
	assign zero_hit = cfg.zero_enable && (pos_ext == off_ext || pos_ext == off1_ext);
	assign byte_eff = zero_hit ? 8'h00 : data_byte;

	// pseudo-header words, carries folded later in the back end
	assign psum = PSUM_W'(src_addr[31:16]) + PSUM_W'(src_addr[15:0])
		+ PSUM_W'(dst_addr[31:16]) + PSUM_W'(dst_addr[15:0])
		+ PSUM_W'(protocol) + PSUM_W'(segment_len);

	always_comb begin
		op.last = last;
		if (kind == KIND_START) begin
			op.kind = OP_LOAD;
			op.val  = cfg.include_pseudo ? psum : '0;
		end else begin
			op.kind = OP_ADD;
			if (odd_q) begin
				op.val = PSUM_W'({held_q, byte_eff});
			end else if (last) begin
				op.val = PSUM_W'({byte_eff, 8'h00});	// odd tail, zero pad
			end else begin
				op.val = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			odd_q  <= 1'b0;
			held_q <= '0;
		end else if (accept) begin
			if (last || kind == KIND_START) begin
				pos_q  <= '0;
				odd_q  <= 1'b0;
				held_q <= '0;
			end else begin
				odd_q  <= !odd_q;
				held_q <= odd_q ? 8'h00 : byte_eff;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> !odd_q && pos_q == '0)
		else $error("front state not cleared after last item");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == KIND_DATA && !last && pos_q == POS_MAX |=> pos_q == POS_MAX)
		else $error("byte position did not saturate");

endmodule

/* sv/ics_queue.sv */
// Two-entry queue of summing operations between front and back end.
module ics_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ics_pkg::ics_op_t push_op,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output ics_pkg::ics_op_t head_op
);
	import ics_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ics_op_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign avail   = (count_q != '0);
	assign head_op = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !avail))
		else $error("queue overflow or underflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count out of step");

endmodule

/* sv/ics_back.sv */
// Back end: ones' complement accumulator and result register.
module ics_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  ics_pkg::ics_op_t head_op,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [15:0]      checksum_value
);
	import ics_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic [PSUM_W-1:0] pre;
	logic              out_free;

	assign out_free = !out_valid || !out_stall;
	assign pop      = avail && (!head_op.last || out_free);

	always_comb begin
		unique case (head_op.kind)
			OP_LOAD: pre = head_op.val;
			OP_ADD:  pre = PSUM_W'(sum_q) + head_op.val;
			default: pre = head_op.val;
		endcase
		sum_next = oc_fold(pre);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop && head_op.last) begin
				sum_q     <= '0;
				out_valid <= 1'b1;
			end else begin
				if (out_valid && !out_stall) begin
					out_valid <= 1'b0;
				end
				if (pop) begin
					sum_q <= sum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_op.last) begin
			checksum_value <= ~sum_next;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && head_op.last && out_valid && out_stall))
		else $error("result overwritten while held");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_op.last |=> sum_q == '0 && out_valid)
		else $error("accumulator not cleared after result");

endmodule

/* sv/internet_checksum_pseudo_header.sv */
// Top level of the internet checksum engine with IPv4 pseudo-header.
//
//  channel | handshake               | carries
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid / in_stall     | kind, src_addr, dst_addr, protocol,
//          |                         | segment_len, data_byte, last
//  out     | out_valid / out_stall   | checksum_value
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per clock sustained while the op queue is not full. A result shows on
// out after its last item passes the op queue and the result register, once the
// result register is free. A two-entry op queue sits between the byte-pairing
// front end and the accumulator; in_stall rises only when that queue is full.
// Reset (arst_n low) restores include_pseudo=1, zero_enable=1, zero_offset=6
// and empties sum, byte position, held byte and queue. No clearing pass.
// cfg_ready is always high; writes to an unused index are dropped.
module internet_checksum_pseudo_header #(
	parameter int MAX_SEGMENT_BYTES = ics_pkg::MAX_SEGMENT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [7:0]  protocol,
	input  logic [15:0] segment_len,
	input  logic [7:0]  data_byte,
	input  logic        last,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] checksum_value,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ics_pkg::*;

	ics_cfg_t cfg_q;
	ics_op_t  front_op;
	ics_op_t  head_op;
	logic     accept;
	logic     q_full;
	logic     q_avail;
	logic     q_pop;

	assign cfg_ready = 1'b1;

	// config registers; user to write only while the engine is idle, unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.include_pseudo <= 1'b1;
			cfg_q.zero_enable    <= 1'b1;
			cfg_q.zero_offset    <= ZERO_OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INCLUDE_PSEUDO: cfg_q.include_pseudo <= cfg_data[0];
				REG_ZERO_ENABLE:    cfg_q.zero_enable    <= cfg_data[0];
				REG_ZERO_OFFSET:    cfg_q.zero_offset    <= cfg_data;
				default: ;
			endcase
		end
	end

	// an item goes straight into the queue once accepted
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	ics_front #(
		.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cfg        (cfg_q),
		.kind       (kind),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.protocol   (protocol),
		.segment_len(segment_len),
		.data_byte  (data_byte),
		.last       (last),
		.op         (front_op)
	);

	ics_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.push_op(front_op),
		.full   (q_full),
		.pop    (q_pop),
		.avail  (q_avail),
		.head_op(head_op)
	);

	// accumulator keeps draining non-final ops even while a result is held
	ics_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.avail         (q_avail),
		.head_op       (head_op),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.checksum_value(checksum_value)
	);

endmodule
